>>> src/tlpt_pkg.sv
package tlpt_pkg;

  localparam int WORD_W      = 32;
  localparam int KIND_W      = 2;
  localparam int FLAGS_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int FRAME_W     = 20;
  localparam int IDX_W       = 10;
  localparam int OFS_W       = 12;
  localparam int DIR_SHIFT   = 22;
  localparam int TBL_SHIFT   = 12;
  localparam int DIR_ENTRIES = 1024;
  localparam int TBL_ENTRIES = 1024;

  localparam logic [OFS_W-1:0] BIT_PRESENT = 12'h001;
  localparam logic [OFS_W-1:0] BIT_RW      = 12'h002;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAP   = 2'd0,
    KIND_UNMAP = 2'd1,
    KIND_XLATE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMAP = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_POOL,
    S_HOLD
  } state_t;

endpackage

>>> src/tlpt_ifs.sv
interface tlpt_req_if;
  logic                          valid;
  logic                          ready;
  logic [tlpt_pkg::KIND_W-1:0]   kind;
  logic [tlpt_pkg::WORD_W-1:0]   virt_addr;
  logic [tlpt_pkg::WORD_W-1:0]   phys_in;
  logic [tlpt_pkg::FLAGS_W-1:0]  page_flags;

  modport source (output valid, kind, virt_addr, phys_in, page_flags, input ready);
  modport sink (input valid, kind, virt_addr, phys_in, page_flags, output ready);
endinterface

interface tlpt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tlpt_pkg::STATUS_W-1:0] status;
  logic [tlpt_pkg::WORD_W-1:0]   xlat_addr;

  modport source (output valid, status, xlat_addr, input ready);
  modport sink (input valid, status, xlat_addr, output ready);
endinterface

interface tlpt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tlpt_pkg::FRAME_W-1:0]  table_frame_base;

  modport source (output valid, table_frame_base, input ready);
  modport sink (input valid, table_frame_base, output ready);
endinterface

>>> src/tlpt_dir.sv
module tlpt_dir #(
  parameter int ENTRY_W = 36
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tlpt_pkg::IDX_W-1:0] addr,
  input  logic [ENTRY_W-1:0]         wdata,
  output logic [ENTRY_W-1:0]         rdata
);

  logic [ENTRY_W-1:0] mem [tlpt_pkg::DIR_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/tlpt_pool.sv
module tlpt_pool #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           addr,
  input  logic [tlpt_pkg::WORD_W-1:0] wdata,
  output logic [tlpt_pkg::WORD_W-1:0] rdata
);

  logic [tlpt_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/two_level_page_table_engine_top.sv
// Two-level page table engine: a 1024-entry page directory and a pool of TABLE_SLOTS page
// tables of 1024 entries, each held in single-port synchronous memory. Each request maps,
// unmaps or translates a 32-bit virtual address split 10/10/12; a map installs a table on
// demand from the next pool slot and answers status 2 once the pool is used up. After reset
// the engine sweeps both memories to zero, one pool entry per cycle, and takes no request
// until done; configuration writes are taken at any time.
// One request is handled at a time, and the directory read is issued in its acceptance
// cycle. Map, unmap and a translate that finds no table finish in the directory step
// (S_DIR), which does any directory or table write and registers the result, and then
// the engine returns to idle; a translate that finds a table reads the table entry in a
// further step (S_POOL). The result sits in an output register, so the next request
// is accepted while it waits; a second result that finishes while the first is still
// waiting holds the engine until the register frees.
module two_level_page_table_engine_top #(
  parameter int TABLE_SLOTS = 16
) (
  input logic         clk,
  input logic         rst,
  tlpt_req_if.sink    req,
  tlpt_rsp_if.source  rsp,
  tlpt_cfg_if.sink    cfg
);

  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int POOL_DEPTH = TABLE_SLOTS * tlpt_pkg::TBL_ENTRIES;
  localparam int PA_W       = $clog2(POOL_DEPTH);
  localparam int DIR_W      = tlpt_pkg::WORD_W + SLOT_W;
  localparam int W          = tlpt_pkg::WORD_W;

  tlpt_pkg::state_t state, state_next;

  logic [PA_W-1:0]             clr_cnt;
  logic [CNT_W-1:0]            next_slot;
  logic [tlpt_pkg::FRAME_W-1:0] table_frame_base;
  logic                        out_valid;
  tlpt_pkg::status_t           out_status;
  logic [W-1:0]                out_addr;
  tlpt_pkg::status_t           res_status;
  logic [W-1:0]                res_addr;

  logic [tlpt_pkg::KIND_W-1:0]  r_kind;
  logic [W-1:0]                 r_va;
  logic [W-1:0]                 r_pa;
  logic [tlpt_pkg::FLAGS_W-1:0] r_flags;

  logic                       dir_we;
  logic [tlpt_pkg::IDX_W-1:0] dir_addr;
  logic [DIR_W-1:0]           dir_wdata;
  logic [DIR_W-1:0]           dir_rdata;
  logic                       pool_we;
  logic [PA_W-1:0]            pool_addr;
  logic [W-1:0]               pool_wdata;
  logic [W-1:0]               pool_rdata;

  logic                        accept;
  logic                        out_free;
  logic                        clr_done;
  logic                        clr_in_dir;
  logic                        dir_hit;
  logic [SLOT_W-1:0]           dir_slot;
  logic [SLOT_W-1:0]           slot_sel;
  logic                        pool_full;
  logic [tlpt_pkg::FRAME_W-1:0] new_frame;
  logic [PA_W-1:0]             pte_addr;
  logic                        slot_inc;
  logic                        fin;
  tlpt_pkg::status_t           fin_status;
  logic [W-1:0]                fin_addr;

  tlpt_dir #(
    .ENTRY_W (DIR_W)
  ) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  tlpt_pool #(
    .DEPTH  (POOL_DEPTH),
    .ADDR_W (PA_W)
  ) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .addr  (pool_addr),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );

  assign req.ready = (state == tlpt_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.xlat_addr = out_addr;

  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign clr_done   = (clr_cnt == PA_W'(POOL_DEPTH - 1));
  assign clr_in_dir = ({1'b0, clr_cnt} < (PA_W + 1)'(tlpt_pkg::DIR_ENTRIES));
  assign dir_hit    = dir_rdata[0];
  assign dir_slot   = dir_rdata[DIR_W-1 -: SLOT_W];
  assign pool_full  = (next_slot == CNT_W'(TABLE_SLOTS));
  assign slot_sel   = dir_hit ? dir_slot : SLOT_W'(next_slot);
  assign new_frame  = table_frame_base + tlpt_pkg::FRAME_W'(next_slot);
  assign pte_addr   = PA_W'({slot_sel, r_va[tlpt_pkg::TBL_SHIFT +: tlpt_pkg::IDX_W]});

  always_comb begin
    state_next = state;
    case (state)
      tlpt_pkg::S_CLEAR: begin
        if (clr_done) begin
          state_next = tlpt_pkg::S_IDLE;
        end
      end
      tlpt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = tlpt_pkg::S_DIR;
        end
      end
      tlpt_pkg::S_DIR: begin
        if (dir_hit && (r_kind == tlpt_pkg::KIND_XLATE)) begin
          state_next = tlpt_pkg::S_POOL;
        end else begin
          state_next = out_free ? tlpt_pkg::S_IDLE : tlpt_pkg::S_HOLD;
        end
      end
      tlpt_pkg::S_POOL, tlpt_pkg::S_HOLD: begin
        state_next = out_free ? tlpt_pkg::S_IDLE : tlpt_pkg::S_HOLD;
      end
      default: begin
        state_next = tlpt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    dir_we     = 1'b0;
    dir_addr   = req.virt_addr[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::IDX_W];
    dir_wdata  = '0;
    pool_we    = 1'b0;
    pool_addr  = pte_addr;
    pool_wdata = '0;
    slot_inc   = 1'b0;
    fin        = 1'b0;
    fin_status = tlpt_pkg::ST_NOMAP;
    fin_addr   = '0;
    case (state)
      tlpt_pkg::S_CLEAR: begin
        dir_we    = clr_in_dir;
        dir_addr  = clr_cnt[tlpt_pkg::IDX_W-1:0];
        pool_we   = 1'b1;
        pool_addr = clr_cnt;
      end
      tlpt_pkg::S_DIR: begin
        dir_addr = r_va[tlpt_pkg::DIR_SHIFT +: tlpt_pkg::IDX_W];
        case (r_kind)
          tlpt_pkg::KIND_MAP: begin
            fin = 1'b1;
            if (!dir_hit && pool_full) begin
              fin_status = tlpt_pkg::ST_FULL;
            end else begin
              if (!dir_hit) begin
                dir_we    = 1'b1;
                dir_wdata = {SLOT_W'(next_slot), new_frame,
                             tlpt_pkg::BIT_PRESENT | tlpt_pkg::BIT_RW};
                slot_inc  = 1'b1;
              end
              pool_we    = 1'b1;
              pool_wdata = {r_pa[W-1:tlpt_pkg::OFS_W], r_flags | tlpt_pkg::BIT_PRESENT};
              fin_status = tlpt_pkg::ST_OK;
            end
          end
          tlpt_pkg::KIND_UNMAP: begin
            fin = 1'b1;
            if (dir_hit) begin
              pool_we    = 1'b1;
              fin_status = tlpt_pkg::ST_OK;
            end
          end
          tlpt_pkg::KIND_XLATE: begin
            fin = !dir_hit;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      tlpt_pkg::S_POOL: begin
        fin = 1'b1;
        if (pool_rdata[0]) begin
          fin_status = tlpt_pkg::ST_OK;
          fin_addr   = {pool_rdata[W-1:tlpt_pkg::OFS_W], r_va[tlpt_pkg::OFS_W-1:0]};
        end
      end
      tlpt_pkg::S_HOLD: begin
        fin        = 1'b1;
        fin_status = res_status;
        fin_addr   = res_addr;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tlpt_pkg::S_CLEAR;
      clr_cnt          <= '0;
      next_slot        <= '0;
      table_frame_base <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tlpt_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + PA_W'(1);
      end
      if (slot_inc) begin
        next_slot <= next_slot + CNT_W'(1);
      end
      if (cfg.valid) begin
        table_frame_base <= cfg.table_frame_base;
      end
      if (fin && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind  <= req.kind;
      r_va    <= req.virt_addr;
      r_pa    <= req.phys_in;
      r_flags <= req.page_flags;
    end
    if (fin && out_free) begin
      out_status <= fin_status;
      out_addr   <= fin_addr;
    end
    if (fin && !out_free) begin
      res_status <= fin_status;
      res_addr   <= fin_addr;
    end
  end

`ifndef SYNTHESIS
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_slot <= CNT_W'(TABLE_SLOTS))
    else $error("pool slot count beyond pool size");

  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (next_slot != $past(next_slot)) |-> (next_slot == $past(next_slot) + CNT_W'(1)))
    else $error("pool slot count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == tlpt_pkg::ST_FULL)) |-> pool_full)
    else $error("pool exhausted reported with free slots");

  a_alloc_dir: assert property (@(posedge clk) disable iff (rst)
    slot_inc |-> (dir_we && pool_we && (state == tlpt_pkg::S_DIR)))
    else $error("slot taken without directory and table write");

  a_pool_write: assert property (@(posedge clk) disable iff (rst)
    pool_we |-> ((state == tlpt_pkg::S_CLEAR) || (state == tlpt_pkg::S_DIR)))
    else $error("table write outside clear or directory step");
`endif

endmodule

>>> tb/page_walk_checker.sv
`timescale 1ns / 100ps

module page_walk_checker
  import tlpt_pkg::*;
#(
  parameter int TABLE_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  tlpt_req_if  req,
  tlpt_rsp_if  rsp,
  tlpt_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] xlat_addr;
  } walk_result_t;

  logic [WORD_W-1:0]  dir_word  [DIR_ENTRIES];
  int                 dir_slot  [DIR_ENTRIES];
  logic [WORD_W-1:0]  pte_store [TABLE_SLOTS*TBL_ENTRIES];
  int                 next_slot;
  logic [FRAME_W-1:0] frame_base;
  walk_result_t       expected_walks [$];
  int                 fail_count = 0;

  assign errors = fail_count;

  task automatic clear_tables();
    foreach (dir_word[i]) begin
      dir_word[i] = '0;
      dir_slot[i] = 0;
    end
    foreach (pte_store[i]) pte_store[i] = '0;
    next_slot  = 0;
    frame_base = '0;
  endtask

  function automatic walk_result_t walk_request(input logic [KIND_W-1:0] kind,
                                                input logic [WORD_W-1:0] va,
                                                input logic [WORD_W-1:0] pa,
                                                input logic [FLAGS_W-1:0] fl);
    int                 slot;
    int                 d;
    int                 t;
    logic [WORD_W-1:0]  pte;
    logic [FRAME_W-1:0] frame;
    walk_result_t       r;
    d           = int'(va[31:DIR_SHIFT]);
    t           = int'(va[DIR_SHIFT-1:TBL_SHIFT]);
    r.status    = ST_NOMAP;
    r.xlat_addr = '0;
    slot        = dir_word[d][0] ? dir_slot[d] : -1;
    if (kind == KIND_MAP) begin
      if (slot < 0) begin
        if (next_slot >= TABLE_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot = next_slot;
          for (int e = 0; e < TBL_ENTRIES; e++) pte_store[slot*TBL_ENTRIES + e] = '0;
          frame       = frame_base + FRAME_W'(slot);
          dir_word[d] = {frame, BIT_PRESENT | BIT_RW};
          dir_slot[d] = slot;
          next_slot++;
        end
      end
      if (slot >= 0) begin
        pte_store[slot*TBL_ENTRIES + t] = {pa[31:TBL_SHIFT], fl | BIT_PRESENT};
        r.status = ST_OK;
      end
    end else if (kind == KIND_UNMAP) begin
      if (slot >= 0) begin
        pte_store[slot*TBL_ENTRIES + t] = '0;
        r.status = ST_OK;
      end
    end else if (kind == KIND_XLATE) begin
      if (slot >= 0) begin
        pte = pte_store[slot*TBL_ENTRIES + t];
        if (pte[0]) begin
          r.xlat_addr = {pte[31:TBL_SHIFT], va[OFS_W-1:0]};
          r.status    = ST_OK;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    walk_result_t want;
    if (rst) begin
      clear_tables();
      expected_walks.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_walks.size() == 0) begin
          fail_count++;
          $error("unexpected response: status %0d xlat_addr %h", rsp.status, rsp.xlat_addr);
        end else begin
          want = expected_walks.pop_front();
          if (rsp.status !== want.status) begin
            fail_count++;
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.xlat_addr !== want.xlat_addr) begin
            fail_count++;
            $error("xlat_addr: expected %h, actual %h", want.xlat_addr, rsp.xlat_addr);
          end
        end
      end
      if (req.valid && req.ready)
        expected_walks.push_back(walk_request(req.kind, req.virt_addr, req.phys_in,
                                              req.page_flags));
      if (cfg.valid && cfg.ready) frame_base = cfg.table_frame_base;
    end
    pending <= expected_walks.size();
  end

endmodule

>>> tb/tb_two_level_page_table_engine_top.sv
`timescale 1ns / 100ps

module tb_two_level_page_table_engine_top;
  import tlpt_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int PHASE_ITEMS = 275;
  localparam int HOT_DIRS    = 20;
  localparam int HOT_TABLES  = 6;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic clk;
  logic rst;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   cycle_no      = 0;
  int   fail_total;
  int   walks_pending;
  logic [IDX_W-1:0] hot_dirs   [HOT_DIRS];
  logic [IDX_W-1:0] hot_tables [HOT_TABLES];

  tlpt_req_if req ();
  tlpt_rsp_if rsp ();
  tlpt_cfg_if cfg ();

  two_level_page_table_engine_top #(.TABLE_SLOTS(TABLE_SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  page_walk_checker #(.TABLE_SLOTS(TABLE_SLOTS)) walk_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .errors  (fail_total),
    .pending (walks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    cycle_no  <= cycle_no + 1;
    rsp.ready <= (cycle_no % 200 < 20) || ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic push_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] va,
                              input logic [WORD_W-1:0] pa, input logic [FLAGS_W-1:0] fl,
                              input bit calm);
    while (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.kind       <= kind;
    req.virt_addr  <= va;
    req.phys_in    <= pa;
    req.page_flags <= fl;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (walks_pending != 0) @(posedge clk);
  endtask

  task automatic write_frame_base(input logic [FRAME_W-1:0] base);
    cfg.valid            <= 1'b1;
    cfg.table_frame_base <= base;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_request(input int n);
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  di;
    logic [IDX_W-1:0]  ti;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      kind = KIND_MAP;
    else if (pick < 50) kind = KIND_UNMAP;
    else if (pick < 95) kind = KIND_XLATE;
    else                kind = KIND_SPARE;
    di = ($urandom_range(0, 99) < 92) ? hot_dirs[$urandom_range(0, HOT_DIRS-1)]
                                      : IDX_W'($urandom);
    ti = ($urandom_range(0, 99) < 85) ? hot_tables[$urandom_range(0, HOT_TABLES-1)]
                                      : IDX_W'($urandom);
    push_request(kind, {di, ti, OFS_W'($urandom)}, $urandom, FLAGS_W'($urandom), n % 50 < 6);
  endtask

  initial begin : stimulus
    logic [FRAME_W-1:0] bases [4];
    rst                  <= 1'b1;
    req.valid            <= 1'b0;
    req.kind             <= KIND_MAP;
    req.virt_addr        <= '0;
    req.phys_in          <= '0;
    req.page_flags       <= '0;
    cfg.valid            <= 1'b0;
    cfg.table_frame_base <= '0;
    foreach (hot_dirs[i]) hot_dirs[i] = IDX_W'($urandom);
    foreach (hot_tables[i]) hot_tables[i] = IDX_W'($urandom);
    bases[0] = '0;
    bases[1] = FRAME_W'($urandom);
    bases[2] = 20'h00001;
    bases[3] = 20'hFFFFE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_frame_base(20'hFFFFF);

    push_request(KIND_XLATE, 32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_UNMAP, 32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_SPARE, 32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
    push_request(KIND_XLATE, 32'hFFFF_FABC, 32'h0, 12'h000, 1'b1);
    push_request(KIND_MAP,   32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_XLATE, 32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_XLATE, 32'h0000_1000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_UNMAP, 32'h0000_1000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_MAP,   32'h0000_0000, 32'h1234_5ABC, 12'h5A4, 1'b1);
    push_request(KIND_XLATE, 32'h0000_0FFF, 32'h0, 12'h000, 1'b1);
    push_request(KIND_UNMAP, 32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_XLATE, 32'h0000_0000, 32'h0, 12'h000, 1'b1);
    push_request(KIND_MAP,   32'hAAAA_AAAA, 32'h5555_5555, 12'hAAA, 1'b1);
    push_request(KIND_XLATE, 32'hAAAA_A555, 32'h0, 12'h000, 1'b1);
    push_request(KIND_MAP,   32'h5555_5555, 32'hAAAA_AAAA, 12'h555, 1'b1);
    push_request(KIND_XLATE, 32'h5555_5AAA, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
    push_request(KIND_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
    push_request(KIND_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 1'b1);
    push_request(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 77;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      settle();
      write_frame_base(bases[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(n);
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
